FILE: sv/q16au_pkg.sv
// ----------------------------------------------------------------------------
// q16au_pkg: shared types and constants of the Q16.16 arithmetic unit
// Op codes, result markers, configuration indexes, payload structs and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package q16au_pkg;

    localparam int DATA_W = 32;
    localparam int PROD_W = 64;
    localparam int CFG_IDX_W = 1;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROUND = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT   = 1'd1;

    localparam logic [DATA_W-1:0] MARKER      = 32'h8000_0000;
    localparam logic [DATA_W-1:0] POS_MAX     = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] NEG_MAX     = 32'h8000_0001;
    localparam logic [DATA_W-1:0] DIV_Q_WRAP  = 32'h8000_0001;
    localparam logic [DATA_W-1:0] BIT_INIT    = 32'h0001_0000;

    localparam logic [PROD_W-1:0] RND_NEG = 64'd32767;
    localparam logic [PROD_W-1:0] RND_POS = 64'd32768;

    typedef struct packed {
        logic [1:0]               op;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic                     overflowed;
        logic                     divide_by_zero;
    } t_out;

    typedef struct packed {
        logic round_enable;
        logic saturate_enable;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic mul;
        logic align;
        logic pre;
        logic div;
        logic rnd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       dz;
        logic       align_more;
        logic       bit_zero;
        logic       dv_top;
        logic       div_more;
    } t_sts;

endpackage

FILE: sv/q16au_dp.sv
// ----------------------------------------------------------------------------
// q16au_dp: datapath of the Q16.16 arithmetic unit
// Operand registers, multiplier, shift-align restoring divider, result
// formatting with overflow marker and saturation, and the output register.
// ----------------------------------------------------------------------------
module q16au_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  q16au_pkg::t_cfg i_cfg,
    input  q16au_pkg::t_in  i_in_data,
    input  q16au_pkg::t_cmd i_cmd,
    output q16au_pkg::t_sts o_sts,
    output q16au_pkg::t_out o_out_data
);
    import q16au_pkg::*;

    logic [1:0]               r_op;
    logic signed [DATA_W-1:0] r_a;
    logic signed [DATA_W-1:0] r_b;
    logic signed [PROD_W-1:0] r_prod;
    logic [DATA_W-1:0]        r_rem;
    logic [DATA_W-1:0]        r_dv;
    logic [DATA_W-1:0]        r_bit;
    logic [DATA_W-1:0]        r_q;
    logic                     r_aovf;
    t_out                     r_out;

    logic [DATA_W-1:0]        abs_a;
    logic [DATA_W-1:0]        abs_b;
    logic                     rem_ge;
    logic [DATA_W-1:0]        rem_sub;
    logic [DATA_W-1:0]        q_set;
    logic signed [PROD_W-1:0] prod_c;
    logic [PROD_W-1:0]        prod_rnd;
    logic                     mul_ok;
    logic [DATA_W-1:0]        mul_raw;
    logic [DATA_W-1:0]        sum;
    logic [DATA_W-1:0]        diff;
    logic [DATA_W-1:0]        add_raw;
    logic [DATA_W-1:0]        sub_raw;
    logic [DATA_W-1:0]        q_neg;
    logic [DATA_W-1:0]        div_raw;
    logic                     dz;
    logic [DATA_W-1:0]        raw;
    logic                     agree;
    t_out                     out_c;

    assign abs_a = i_in_data.operand_a[DATA_W-1] ? (32'd0 - $unsigned(i_in_data.operand_a))
                                                 : $unsigned(i_in_data.operand_a);
    assign abs_b = i_in_data.operand_b[DATA_W-1] ? (32'd0 - $unsigned(i_in_data.operand_b))
                                                 : $unsigned(i_in_data.operand_b);

    // one restoring step
    assign rem_ge  = (r_rem >= r_dv);
    assign rem_sub = rem_ge ? (r_rem - r_dv) : r_rem;
    assign q_set   = r_q | (rem_ge ? r_bit : '0);

    assign prod_c = r_a * r_b;

    // product must lie in [-2^47, 2^47); halves round away from zero
    assign mul_ok   = (r_prod[PROD_W-1:47] == {17{r_prod[PROD_W-1]}});
    assign prod_rnd = $unsigned(r_prod)
                    + (i_cfg.round_enable ? (r_prod[PROD_W-1] ? RND_NEG : RND_POS) : '0);
    assign mul_raw  = mul_ok ? prod_rnd[47:16] : MARKER;

    assign sum  = $unsigned(r_a) + $unsigned(r_b);
    assign diff = $unsigned(r_a) - $unsigned(r_b);
    assign add_raw = ((r_a[DATA_W-1] == r_b[DATA_W-1]) && (sum[DATA_W-1] != r_a[DATA_W-1]))
                   ? MARKER : sum;
    assign sub_raw = ((r_a[DATA_W-1] != r_b[DATA_W-1]) && (diff[DATA_W-1] != r_a[DATA_W-1]))
                   ? MARKER : diff;

    assign dz    = (r_b == '0);
    assign q_neg = 32'd0 - r_q;

    always_comb begin
        if (dz) begin
            div_raw = NEG_MAX;
        end else if (r_aovf) begin
            div_raw = MARKER;
        end else if (r_a[DATA_W-1] != r_b[DATA_W-1]) begin
            div_raw = (r_q == DIV_Q_WRAP) ? MARKER : q_neg;
        end else begin
            div_raw = r_q;
        end
    end

    always_comb begin
        case (r_op)
            OP_ADD: begin
                raw   = add_raw;
                agree = !r_a[DATA_W-1];
            end
            OP_SUB: begin
                raw   = sub_raw;
                agree = !r_a[DATA_W-1];
            end
            OP_MUL: begin
                raw   = mul_raw;
                agree = (r_a[DATA_W-1] == r_b[DATA_W-1]);
            end
            default: begin
                raw   = div_raw;
                agree = (r_a[DATA_W-1] == r_b[DATA_W-1]);
            end
        endcase
    end

    always_comb begin
        out_c.overflowed     = (raw == MARKER);
        out_c.divide_by_zero = (r_op == OP_DIV) && dz;
        if (i_cfg.saturate_enable && (raw == MARKER)) begin
            out_c.result = $signed(agree ? POS_MAX : NEG_MAX);
        end else begin
            out_c.result = $signed(raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_in_data.op;
            r_a    <= i_in_data.operand_a;
            r_b    <= i_in_data.operand_b;
            r_rem  <= abs_a;
            r_dv   <= abs_b;
            r_bit  <= BIT_INIT;
            r_q    <= '0;
            r_aovf <= 1'b0;
        end else if (i_cmd.mul) begin
            r_prod <= prod_c;
        end else if (i_cmd.align) begin
            if (o_sts.align_more) begin
                r_dv  <= {r_dv[DATA_W-2:0], 1'b0};
                r_bit <= {r_bit[DATA_W-2:0], 1'b0};
            end else begin
                // quotient bit shifted out: alignment overflow
                r_aovf <= (r_bit == '0);
            end
        end else if (i_cmd.pre) begin
            r_rem <= rem_sub;
            r_q   <= q_set;
            r_dv  <= {1'b0, r_dv[DATA_W-1:1]};
            r_bit <= {1'b0, r_bit[DATA_W-1:1]};
        end else if (i_cmd.div) begin
            r_rem <= {rem_sub[DATA_W-2:0], 1'b0};
            r_q   <= q_set;
            r_bit <= {1'b0, r_bit[DATA_W-1:1]};
        end else if (i_cmd.rnd) begin
            r_q <= r_q + {{(DATA_W-1){1'b0}}, (i_cfg.round_enable && rem_ge)};
        end
        if (i_cmd.out_load) begin
            r_out <= out_c;
        end
    end

    assign o_sts.op         = r_op;
    assign o_sts.dz         = dz;
    assign o_sts.align_more = (r_dv < r_rem) && (r_bit != '0);
    assign o_sts.bit_zero   = (r_bit == '0);
    assign o_sts.dv_top     = r_dv[DATA_W-1];
    assign o_sts.div_more   = (r_bit != '0) && (r_rem != '0);

    assign o_out_data = r_out;

    a_div_dv_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div |-> !r_dv[DATA_W-1])
        else $error("divisor top bit set during main division step");

    a_pre_only_wide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pre |-> (r_dv[DATA_W-1] && (r_bit != '0)))
        else $error("pre-step taken without wide divisor");

    a_load_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> ((r_q == '0) && (r_bit == BIT_INIT) && !r_aovf))
        else $error("divider state not initialised on load");

endmodule

FILE: sv/q16au_ctrl.sv
// ----------------------------------------------------------------------------
// q16au_ctrl: controller of the Q16.16 arithmetic unit
// Sequences load, multiply, divider alignment and steps, rounding and the
// hand-off to the output register; owns the input stall and output valid.
// ----------------------------------------------------------------------------
module q16au_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  q16au_pkg::t_sts i_sts,
    output q16au_pkg::t_cmd o_cmd
);
    import q16au_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_ALIGN = 7'b0000100,
        S_PRE   = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_RND   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_sts.op)
                    OP_MUL: begin
                        o_cmd.mul = 1'b1;
                        n_state   = S_OUT;
                    end
                    OP_DIV: begin
                        n_state = S_ALIGN;
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_ALIGN: begin
                o_cmd.align = 1'b1;
                if (i_sts.dz) begin
                    n_state = S_OUT;
                end else if (i_sts.align_more) begin
                    n_state = S_ALIGN;
                end else if (i_sts.bit_zero) begin
                    n_state = S_OUT;
                end else if (i_sts.dv_top) begin
                    n_state = S_PRE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_PRE: begin
                o_cmd.pre = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_more) begin
                    o_cmd.div = 1'b1;
                end else begin
                    n_state = S_RND;
                end
            end
            S_RND: begin
                o_cmd.rnd = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_EXEC))
        else $error("accepted item not dispatched");

    a_dz_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ALIGN) && i_sts.dz) |=> (r_state == S_OUT))
        else $error("divide by zero did not skip the divider");

    a_out_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (o_out_valid && (r_state == S_IDLE)))
        else $error("result hand-off incomplete");

endmodule

FILE: sv/q16_16_arith_unit.sv
// ----------------------------------------------------------------------------
// q16_16_arith_unit: Q16.16 add, subtract, multiply and divide
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-------------------------
//   in      | input     | i_in_valid / o_in_stall  | i_in_data  (t_in)
//   out     | output    | o_out_valid / i_out_stall| o_out_data (t_out)
//   cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One item at a time. Add, subtract and multiply pass through the execute
// and output states after acceptance; divide also runs the divider's
// alignment shifts (up to 16) and its restoring steps (up to 32), one per cycle.
// A new item is taken as soon as the result sits in the output register,
// even while the result is stalled. Synchronous active-low reset sets
// round_enable and clears saturate_enable; configuration is always ready.
// ----------------------------------------------------------------------------
module q16_16_arith_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  q16au_pkg::t_in                   i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output q16au_pkg::t_out                  o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [q16au_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic                             i_cfg_data
);
    import q16au_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.round_enable    <= 1'b1;
            r_cfg.saturate_enable <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ROUND: r_cfg.round_enable    <= i_cfg_data;
                CFG_SAT:   r_cfg.saturate_enable <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    q16au_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    q16au_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule

FILE: test/tb_q16_16_arith_unit.sv
// ----------------------------------------------------------------------------
// tb_q16_16_arith_unit: self-checking bench for the Q16.16 arithmetic unit
// A directed run over the operand extremes, overflow markers, rounding halves
// and divider corners, then randomised phases under every round/saturate
// setting. Each accepted item is predicted on entry and compared in order
// with the results that leave the block, under bursty input and output stalls.
// ----------------------------------------------------------------------------
module tb_q16_16_arith_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import q16au_pkg::*;

    localparam int QUIET_LIMIT   = 3000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int HOLD_CYCLES   = 250;
    localparam int PHASE_ITEMS   = 146;
    localparam int REPORT_MAX    = 10;
    localparam logic signed [63:0] PROD_LIMIT = 64'sh0000_8000_0000_0000;
    localparam logic signed [63:0] PROD_TOP   = 64'sh0000_0000_7FFF_FFFF;

    typedef struct packed {
        t_in  item;
        t_out want;
    } q16_case_t;

    logic                 i_clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in                  in_data   = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_ROUND;
    logic                 cfg_data  = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out                 o_out_data;
    logic                 o_cfg_ready;

    // shadow of the unit's configuration, as after reset
    logic round_on = 1'b1;
    logic sat_on   = 1'b0;

    t_in       pending_items[$];
    q16_case_t awaited_results[$];
    int        mismatch_count = 0;
    int        results_seen   = 0;

    q16_16_arith_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Expected result of one item under the current configuration
    function automatic q16_case_t predict_q16(t_in item);
        q16_case_t         c;
        logic [31:0]       ua, ub, raw, rem, dv, qbit, quo;
        logic signed [63:0] wide_a, wide_b, prod, scaled;
        logic              agree, dz;
        ua = item.operand_a;
        ub = item.operand_b;
        dz = 1'b0;
        agree = (ua[31] == ub[31]);
        case (item.op)
            OP_ADD: begin
                raw = ua + ub;
                if (ua[31] == ub[31] && raw[31] != ua[31]) raw = MARKER;
                agree = !ua[31];
            end
            OP_SUB: begin
                raw = ua - ub;
                if (ua[31] != ub[31] && raw[31] != ua[31]) raw = MARKER;
                agree = !ua[31];
            end
            OP_MUL: begin
                wide_a = {{32{ua[31]}}, ua};
                wide_b = {{32{ub[31]}}, ub};
                prod = wide_a * wide_b;
                if (prod >= PROD_LIMIT || prod < -PROD_LIMIT) begin
                    raw = MARKER;
                end else begin
                    if (round_on)
                        scaled = (prod + ((prod < 0) ? 64'sd32767 : 64'sd32768)) >>> 16;
                    else
                        scaled = prod >>> 16;
                    raw = (scaled > PROD_TOP) ? MARKER : scaled[31:0];
                end
            end
            default: begin
                if (ub == '0) begin
                    raw = NEG_MAX;
                    dz = 1'b1;
                end else begin
                    rem  = ua[31] ? 32'd0 - ua : ua;
                    dv   = ub[31] ? 32'd0 - ub : ub;
                    qbit = BIT_INIT;
                    quo  = '0;
                    // align the divisor, then one restoring step per quotient bit
                    while (dv < rem) begin
                        dv = dv << 1;
                        qbit = qbit << 1;
                    end
                    if (qbit == '0) begin
                        raw = MARKER;
                    end else begin
                        if (dv[31]) begin
                            if (rem >= dv) begin
                                quo = quo | qbit;
                                rem = rem - dv;
                            end
                            dv = dv >> 1;
                            qbit = qbit >> 1;
                        end
                        while (qbit != '0 && rem != '0) begin
                            if (rem >= dv) begin
                                quo = quo | qbit;
                                rem = rem - dv;
                            end
                            rem = rem << 1;
                            qbit = qbit >> 1;
                        end
                        if (round_on && rem >= dv) quo = quo + 32'd1;
                        if (ua[31] != ub[31])
                            raw = (quo == DIV_Q_WRAP) ? MARKER : 32'd0 - quo;
                        else
                            raw = quo;
                    end
                end
            end
        endcase
        c.item = item;
        c.want.overflowed = (raw == MARKER);
        c.want.divide_by_zero = dz;
        if (sat_on && raw == MARKER) raw = agree ? POS_MAX : NEG_MAX;
        c.want.result = raw;
        return c;
    endfunction

    function automatic t_in arith_item(logic [1:0] op, logic [31:0] a, logic [31:0] b);
        t_in it;
        it.op = op;
        it.operand_a = a;
        it.operand_b = b;
        return it;
    endfunction

    // Operand mix: full range, small values, extremes, powers of two, scaled noise
    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            1: begin
                case ($urandom_range(0, 8))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h8000_0001;
                    3: v = 32'h0000_0000;
                    4: v = 32'h0001_0000;
                    5: v = 32'hFFFF_0000;
                    6: v = 32'h0000_0001;
                    7: v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_8000;
                endcase
            end
            2: begin
                v = 32'h1 << $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1) v = 32'd0 - v;
            end
            3: begin
                v = $urandom() >> $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1) v = ~v;
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || awaited_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_ROUND) round_on = val;
        else sat_on = val;
    endtask

    // Sender: bursts of random length separated by random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) awaited_results.push_back(predict_q16(in_data));
            if (!in_valid || !o_in_stall) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    in_data  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 16);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result, stall on a changing pattern, hold off twice
    int unsigned hold_left    = 0;
    int unsigned pattern_tick = 0;
    int unsigned stall_mode   = 0;

    always @(posedge i_clk) begin
        q16_case_t c;
        logic      took;
        took = o_out_valid && !out_stall;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (took) begin
                if (awaited_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected result %h ovf %0b dz %0b", o_out_data.result,
                                 o_out_data.overflowed, o_out_data.divide_by_zero);
                end else begin
                    c = awaited_results.pop_front();
                    if (o_out_data.result !== c.want.result
                        || o_out_data.overflowed !== c.want.overflowed
                        || o_out_data.divide_by_zero !== c.want.divide_by_zero) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("mismatch op %0d a %h b %h: got %h/%0b/%0b want %h/%0b/%0b",
                                     c.item.op, c.item.operand_a, c.item.operand_b,
                                     o_out_data.result, o_out_data.overflowed,
                                     o_out_data.divide_by_zero, c.want.result,
                                     c.want.overflowed, c.want.divide_by_zero);
                    end
                end
                results_seen++;
            end
            pattern_tick++;
            if (pattern_tick % 128 == 0) stall_mode = $urandom_range(0, 3);
            // hold off long enough for the unit to back up onto its input
            if (took && (results_seen == 100 || results_seen == 400)) begin
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 1) == 0);
                    2: out_stall <= (pattern_tick % 8 < 3);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Watchdog on cycles in which no handshake completes
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)
            || (cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic [1:0] round_plan[4];
        logic [1:0] sat_plan[4];
        t_in        it;
        round_plan = '{2'd0, 2'd1, 2'd0, 2'd1};
        sat_plan   = '{2'd1, 2'd1, 2'd0, 2'd0};
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // directed run under the reset configuration
        pending_items.push_back(arith_item(OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001));
        pending_items.push_back(arith_item(OP_ADD, 32'h8000_0000, 32'h0000_0000));
        pending_items.push_back(arith_item(OP_ADD, 32'h8000_0000, 32'hFFFF_FFFF));
        pending_items.push_back(arith_item(OP_SUB, 32'h8000_0000, 32'h0000_0001));
        pending_items.push_back(arith_item(OP_SUB, 32'h7FFF_FFFF, 32'h8000_0000));
        pending_items.push_back(arith_item(OP_SUB, 32'h0000_0000, 32'h8000_0000));
        pending_items.push_back(arith_item(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_items.push_back(arith_item(OP_MUL, 32'h0000_0001, 32'h0000_8000));
        pending_items.push_back(arith_item(OP_MUL, 32'hFFFF_FFFF, 32'h0000_8000));
        pending_items.push_back(arith_item(OP_MUL, 32'h0080_0000, 32'h0100_0000));
        pending_items.push_back(arith_item(OP_MUL, 32'hFF80_0000, 32'h0100_0000));
        // rounds up past the positive maximum
        pending_items.push_back(arith_item(OP_MUL, 32'h0101_0101, 32'h007F_8000));
        pending_items.push_back(arith_item(OP_DIV, 32'h0001_0000, 32'h0000_0000));
        pending_items.push_back(arith_item(OP_DIV, 32'h8000_0000, 32'h0001_0000));
        pending_items.push_back(arith_item(OP_DIV, 32'h7FFF_FFFF, 32'h0000_0001));
        pending_items.push_back(arith_item(OP_DIV, 32'h0001_0000, 32'h0003_0000));
        pending_items.push_back(arith_item(OP_DIV, 32'hFFFF_0000, 32'h0003_0000));
        pending_items.push_back(arith_item(OP_DIV, 32'h0000_0000, 32'hFFFF_0000));

        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            write_cfg(CFG_ROUND, round_plan[ph][0]);
            write_cfg(CFG_SAT, sat_plan[ph][0]);
            @(negedge i_clk);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                it.op = $urandom_range(0, 3);
                it.operand_a = pick_operand();
                it.operand_b = pick_operand();
                pending_items.push_back(it);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
